[design/pptrk_pkg.sv]
// ----------------------------------------------------------------------------
// pptrk_pkg: shared types and constants of the path-mtu probe tracker
// Word layouts, action and register codes, reset values and queue sizing.
// ----------------------------------------------------------------------------
package pptrk_pkg;

  // field widths
  localparam int PN_W      = 62;
  localparam int WIDE_W    = 64;
  localparam int SIZE_W    = 16;
  localparam int STEP_W    = 11;
  localparam int ACTION_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // action codes on the input word
  localparam logic [ACTION_W-1:0] ACT_START  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_RESULT = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_RESET  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_HDR    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_RANGE  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_PROBE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_STEP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PROBE_SIZE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATH_MIN_MTU    = 2'd3;

  // reset values
  localparam logic [SIZE_W-1:0] BASE_PROBE_SIZE_RST = 16'd1450;
  localparam logic [STEP_W-1:0] PROBE_STEP_RST      = 11'd50;
  localparam logic [SIZE_W-1:0] MAX_PROBE_SIZE_RST  = 16'd1500;
  localparam logic [SIZE_W-1:0] PATH_MIN_MTU_RST    = 16'd1200;
  localparam logic [SIZE_W-1:0] LIMIT_RST           = 16'd1450;
  localparam logic [SIZE_W-1:0] TARGET_RST          = 16'd1450;

  // rfc 9000 range decode: next high bound is cursor - gap - 2
  localparam logic [WIDE_W-1:0] GAP_BIAS = 64'd2;

  // input word
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [PN_W-1:0]     packet_number;
    logic                success;
    logic                is_ack_frame;
    logic [PN_W-1:0]     largest_acked;
    logic [PN_W-1:0]     first_len;
    logic [PN_W-1:0]     gap;
    logic [PN_W-1:0]     range_length;
  } in_word_t;

  // result word
  typedef struct packed {
    logic              covered;
    logic [SIZE_W-1:0] mtu_limit;
    logic [SIZE_W-1:0] probe_target;
    logic              probe_pending;
  } out_word_t;

  // classified operation
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_START  = 3'd1,
    OP_RESULT = 3'd2,
    OP_RESET  = 3'd3,
    OP_HDR    = 3'd4,
    OP_RANGE  = 3'd5
  } op_t;

  // queue entry: operation with pre-computed operands
  //   start : arg_a = packet number
  //   result: flag = success
  //   header: flag = is ack, arg_a = largest, arg_b = largest - first
  //   range : arg_a = gap + 2, arg_b = gap + 2 + length, arg_c = length
  typedef struct packed {
    op_t               op;
    logic              flag;
    logic [WIDE_W-1:0] arg_a;
    logic [WIDE_W-1:0] arg_b;
    logic [WIDE_W-1:0] arg_c;
  } entry_t;

  // configuration register set
  typedef struct packed {
    logic [SIZE_W-1:0] base_probe_size;
    logic [STEP_W-1:0] probe_step;
    logic [SIZE_W-1:0] max_probe_size;
    logic [SIZE_W-1:0] path_min_mtu;
  } cfg_regs_t;

  // status from the back part
  typedef struct packed {
    logic              inflight;
    logic              walk_active;
    logic [SIZE_W-1:0] limit;
  } bk_status_t;

endpackage

[design/pmtu_probe_ack_tracker_core.sv]
// ----------------------------------------------------------------------------
// pmtu_probe_ack_tracker_core: path-mtu probe tracker with ack range check
// Tracks one probe in flight and walks ack ranges to confirm it.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per operation (start probe, probe result, path reset,
//           ack header, ack extra range), valid/ready.
//   out_* : exactly one result word per input word, in order, valid/ready:
//           covered flag, confirmed mtu limit, probe target, pending flag.
//   cfg_* : register writes (base size, step, max size, path minimum),
//           taken at any edge with cfg_we high; write only while idle.
// Flow:
//   an accepted word is decoded combinationally and written into the queue;
//   the back part applies it from the queue head and registers its result.
//   One word per cycle is sustained while out_ready keeps the result register
//   free: the back part applies one queued word each cycle, and each ack range
//   is decoded against the range cursor (two 64-bit subtracts and compares).
// Reset: synchronous rst_n clears the queue, the output valid flag, the probe
//   and walk state; limit and target return to 1450, registers to defaults.
// Stall: while out_ready is low the result is held; the queue absorbs
//   words until full, then in_ready drops.
// ----------------------------------------------------------------------------
module pmtu_probe_ack_tracker_core
  import pptrk_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  cfg_regs_t  cfg_r, cfg_nxt;
  logic       push_valid;
  logic       push_ready;
  entry_t     push_data;
  logic       q_valid;
  logic       q_ready;
  entry_t     q_data;
  bk_status_t bk_status;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_PROBE_SIZE: cfg_nxt.base_probe_size = cfg_wdata;
        CFG_PROBE_STEP:      cfg_nxt.probe_step      = cfg_wdata[STEP_W-1:0];
        CFG_MAX_PROBE_SIZE:  cfg_nxt.max_probe_size  = cfg_wdata;
        CFG_PATH_MIN_MTU:    cfg_nxt.path_min_mtu    = cfg_wdata;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_probe_size <= BASE_PROBE_SIZE_RST;
      cfg_r.probe_step      <= PROBE_STEP_RST;
      cfg_r.max_probe_size  <= MAX_PROBE_SIZE_RST;
      cfg_r.path_min_mtu    <= PATH_MIN_MTU_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: decode
  pptrk_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // queue between front and back
  pptrk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // back: state update and result register
  pptrk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .op_valid  (q_valid),
    .op_ready  (q_ready),
    .op_data   (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .status    (bk_status)
  );

  // a range walk only runs while the probe is in flight
  a_walk_needs_probe: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.walk_active |-> bk_status.inflight)
    else $error("range walk active without probe in flight");

  // a covering ack always retires the probe
  a_covered_retires: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.covered) |-> !out_data.probe_pending)
    else $error("covered result with probe still pending");

  // an accepted word is in the queue on the next cycle
  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> q_valid)
    else $error("accepted word missing from queue");

  // the limit moves only when the back part applies a word
  a_limit_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_valid && q_ready) |=> $stable(bk_status.limit))
    else $error("limit changed without an applied word");

endmodule

[design/pptrk_front.sv]
// ----------------------------------------------------------------------------
// pptrk_front: input decode
// Classifies each input word and pre-computes the state-free operands.
// ----------------------------------------------------------------------------
module pptrk_front
  import pptrk_pkg::*;
(
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  output logic     push_valid,
  input  logic     push_ready,
  output entry_t   push_data
);

  logic [WIDE_W-1:0] largest_w;
  logic [WIDE_W-1:0] first_w;
  logic [WIDE_W-1:0] gap_w;
  logic [WIDE_W-1:0] len_w;

  assign largest_w = {2'b00, in_data.largest_acked};
  assign first_w   = {2'b00, in_data.first_len};
  assign gap_w     = {2'b00, in_data.gap};
  assign len_w     = {2'b00, in_data.range_length};

  // handshake passes straight through to the queue
  assign push_valid = in_valid;
  assign in_ready   = push_ready;

  // classify and build operands
  always_comb begin
    push_data.op    = OP_NONE;
    push_data.flag  = 1'b0;
    push_data.arg_a = '0;
    push_data.arg_b = '0;
    push_data.arg_c = '0;
    case (in_data.action)
      ACT_START: begin
        push_data.op    = OP_START;
        push_data.arg_a = {2'b00, in_data.packet_number};
      end
      ACT_RESULT: begin
        push_data.op   = OP_RESULT;
        push_data.flag = in_data.success;
      end
      ACT_RESET: begin
        push_data.op = OP_RESET;
      end
      ACT_HDR: begin
        push_data.op    = OP_HDR;
        push_data.flag  = in_data.is_ack_frame;
        push_data.arg_a = largest_w;
        // low bound of the first range, wraps in 64 bits
        push_data.arg_b = largest_w - first_w;
      end
      ACT_RANGE: begin
        push_data.op    = OP_RANGE;
        push_data.arg_a = gap_w + GAP_BIAS;
        push_data.arg_b = gap_w + len_w + GAP_BIAS;
        push_data.arg_c = len_w;
      end
      default: begin
        push_data.op = OP_NONE;
      end
    endcase
  end

endmodule

[design/pptrk_queue.sv]
// ----------------------------------------------------------------------------
// pptrk_queue: short fifo between front and back
// Register-based queue; head is read combinationally.
// ----------------------------------------------------------------------------
module pptrk_queue
  import pptrk_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_data,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = store_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[design/pptrk_back.sv]
// ----------------------------------------------------------------------------
// pptrk_back: probe state and ack range walk
// Applies one queued op a cycle unless out_ready stalls; registers the result.
// ----------------------------------------------------------------------------
module pptrk_back
  import pptrk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_regs_t  cfg,
  input  logic       op_valid,
  output logic       op_ready,
  input  entry_t     op_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data,
  output bk_status_t status
);

  logic              inflight_r, inflight_nxt;
  logic [PN_W-1:0]   probe_number_r, probe_number_nxt;
  logic [SIZE_W-1:0] limit_r, limit_nxt;
  logic [SIZE_W-1:0] target_r, target_nxt;
  logic              walk_r, walk_nxt;
  logic [WIDE_W-1:0] cursor_r, cursor_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_data_r, out_data_nxt;

  logic              take;
  logic              covered;
  logic [WIDE_W-1:0] pn_w;
  logic [SIZE_W:0]   stepped;
  logic [WIDE_W-1:0] high;
  logic [WIDE_W-1:0] low_cand;
  logic [WIDE_W-1:0] low;

  assign op_ready = !out_valid_r || out_ready;
  assign take     = op_valid && op_ready;
  assign pn_w     = {2'b00, probe_number_r};

  // start target: base size when limit is below it, else limit plus step, capped
  assign stepped = {1'b0, limit_r} + {6'b0, cfg.probe_step};

  // range decode: high = cursor - gap - 2, low = high - length clamped at zero
  assign high     = cursor_r - op_data.arg_a;
  assign low_cand = cursor_r - op_data.arg_b;
  assign low      = (high >= op_data.arg_c) ? low_cand : '0;

  // next state
  always_comb begin
    inflight_nxt     = inflight_r;
    probe_number_nxt = probe_number_r;
    limit_nxt        = limit_r;
    target_nxt       = target_r;
    walk_nxt         = walk_r;
    cursor_nxt       = cursor_r;
    covered          = 1'b0;
    case (op_data.op)
      OP_START: begin
        if (limit_r < cfg.base_probe_size) begin
          target_nxt = cfg.base_probe_size;
        end else if (stepped < {1'b0, cfg.max_probe_size}) begin
          target_nxt = stepped[SIZE_W-1:0];
        end else begin
          target_nxt = cfg.max_probe_size;
        end
        probe_number_nxt = op_data.arg_a[PN_W-1:0];
        inflight_nxt     = 1'b1;
        walk_nxt         = 1'b0;
      end
      OP_RESULT: begin
        if (inflight_r) begin
          if (op_data.flag) begin
            limit_nxt = target_r;
          end
          inflight_nxt = 1'b0;
        end
        walk_nxt = 1'b0;
      end
      OP_RESET: begin
        inflight_nxt     = 1'b0;
        probe_number_nxt = '0;
        limit_nxt        = cfg.path_min_mtu;
        walk_nxt         = 1'b0;
      end
      OP_HDR: begin
        walk_nxt = 1'b0;
        if (inflight_r && (probe_number_r != '0) && op_data.flag &&
            (pn_w <= op_data.arg_a)) begin
          if (pn_w >= op_data.arg_b) begin
            limit_nxt    = target_r;
            inflight_nxt = 1'b0;
            covered      = 1'b1;
          end else begin
            cursor_nxt = op_data.arg_b;
            walk_nxt   = 1'b1;
          end
        end
      end
      OP_RANGE: begin
        if (walk_r) begin
          if ((pn_w >= low) && (pn_w <= high)) begin
            if (inflight_r) begin
              limit_nxt    = target_r;
              inflight_nxt = 1'b0;
            end
            covered  = 1'b1;
            walk_nxt = 1'b0;
          end else begin
            cursor_nxt = low;
          end
        end
      end
      default: begin
        covered = 1'b0;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (take) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.covered       = covered;
      out_data_nxt.mtu_limit     = limit_nxt;
      out_data_nxt.probe_target  = target_nxt;
      out_data_nxt.probe_pending = inflight_nxt;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r     <= 1'b0;
      probe_number_r <= '0;
      limit_r        <= LIMIT_RST;
      target_r       <= TARGET_RST;
      walk_r         <= 1'b0;
      cursor_r       <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (take) begin
        inflight_r     <= inflight_nxt;
        probe_number_r <= probe_number_nxt;
        limit_r        <= limit_nxt;
        target_r       <= target_nxt;
        walk_r         <= walk_nxt;
        cursor_r       <= cursor_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_data           = out_data_r;
  assign status.inflight    = inflight_r;
  assign status.walk_active = walk_r;
  assign status.limit       = limit_r;

endmodule

[tb/sv/pptrk_status_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pptrk_status_checker: result checker for the path-mtu probe tracker
// Watches the input, result and register ports, keeps its own copy of the
// probe and range-walk state, predicts one status word per accepted input
// word and compares every accepted result word against the oldest prediction.
// ----------------------------------------------------------------------------
module pptrk_status_checker
  import pptrk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_word_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output int                   fail_count,
  output int                   n_due
);

  localparam int SHOWN_MAX = 10;
  localparam logic [WIDE_W-1:0] RANGE_BIAS = 64'd2;

  // shadow register set
  logic [SIZE_W-1:0] base_size;
  logic [STEP_W-1:0] step_size;
  logic [SIZE_W-1:0] max_size;
  logic [SIZE_W-1:0] min_mtu;

  // shadow probe and walk state
  logic              probe_live;
  logic [PN_W-1:0]   probe_pn;
  logic [SIZE_W-1:0] limit_sz;
  logic [SIZE_W-1:0] target_sz;
  logic              walking;
  logic [WIDE_W-1:0] cursor;

  out_word_t status_due_q[$];
  int        errs = 0;

  // apply one input word to the shadow state, return the status it yields
  function automatic out_word_t track_word(input in_word_t w);
    logic              hit;
    logic [SIZE_W:0]   stepped;
    logic [WIDE_W-1:0] lo;
    logic [WIDE_W-1:0] hi;
    out_word_t         r;
    hit = 1'b0;
    case (w.action)
      ACT_START: begin
        stepped = {1'b0, limit_sz} + {6'd0, step_size};
        if (limit_sz < base_size) begin
          target_sz = base_size;
        end else if (stepped < {1'b0, max_size}) begin
          target_sz = stepped[SIZE_W-1:0];
        end else begin
          target_sz = max_size;
        end
        probe_pn   = w.packet_number;
        probe_live = 1'b1;
        walking    = 1'b0;
      end
      ACT_RESULT: begin
        if (probe_live && w.success) limit_sz = target_sz;
        probe_live = 1'b0;
        walking    = 1'b0;
      end
      ACT_RESET: begin
        probe_live = 1'b0;
        probe_pn   = '0;
        limit_sz   = min_mtu;
        walking    = 1'b0;
      end
      ACT_HDR: begin
        walking = 1'b0;
        if (probe_live && probe_pn != '0 && w.is_ack_frame &&
            probe_pn <= w.largest_acked) begin
          // first range low bound wraps when the range is wider than largest
          lo = {2'b00, w.largest_acked} - {2'b00, w.first_len};
          if ({2'b00, probe_pn} >= lo) begin
            limit_sz   = target_sz;
            probe_live = 1'b0;
            hit        = 1'b1;
          end else begin
            cursor  = lo;
            walking = 1'b1;
          end
        end
      end
      ACT_RANGE: begin
        if (walking) begin
          // next high bound wraps, low bound clamps at zero
          hi = cursor - {2'b00, w.gap} - RANGE_BIAS;
          lo = (hi >= {2'b00, w.range_length}) ? hi - {2'b00, w.range_length} : '0;
          if ({2'b00, probe_pn} >= lo && {2'b00, probe_pn} <= hi) begin
            if (probe_live) limit_sz = target_sz;
            probe_live = 1'b0;
            hit        = 1'b1;
            walking    = 1'b0;
          end else begin
            cursor = lo;
          end
        end
      end
      default: ;
    endcase
    r.covered       = hit;
    r.mtu_limit     = limit_sz;
    r.probe_target  = target_sz;
    r.probe_pending = probe_live;
    return r;
  endfunction

  // compare one field, report the first few misses
  task automatic check_field(input string name, input logic [SIZE_W-1:0] want,
                             input logic [SIZE_W-1:0] got);
    if (got !== want) begin
      if (errs < SHOWN_MAX) begin
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
      errs++;
    end
  endtask

  // track the channels at every edge
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      base_size  = BASE_PROBE_SIZE_RST;
      step_size  = PROBE_STEP_RST;
      max_size   = MAX_PROBE_SIZE_RST;
      min_mtu    = PATH_MIN_MTU_RST;
      probe_live = 1'b0;
      probe_pn   = '0;
      limit_sz   = LIMIT_RST;
      target_sz  = TARGET_RST;
      walking    = 1'b0;
      cursor     = '0;
      status_due_q.delete();
    end else begin
      // result side: oldest prediction first
      if (out_valid && out_ready) begin
        if (status_due_q.size() == 0) begin
          if (errs < SHOWN_MAX) $display("unexpected result word %h", out_data);
          errs++;
        end else begin
          want = status_due_q.pop_front();
          check_field("covered", SIZE_W'(want.covered), SIZE_W'(out_data.covered));
          check_field("mtu_limit", want.mtu_limit, out_data.mtu_limit);
          check_field("probe_target", want.probe_target, out_data.probe_target);
          check_field("probe_pending", SIZE_W'(want.probe_pending),
                      SIZE_W'(out_data.probe_pending));
        end
      end
      // input side
      if (in_valid && in_ready) status_due_q.push_back(track_word(in_data));
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_PROBE_SIZE: base_size = cfg_wdata[SIZE_W-1:0];
          CFG_PROBE_STEP:      step_size = cfg_wdata[STEP_W-1:0];
          CFG_MAX_PROBE_SIZE:  max_size  = cfg_wdata[SIZE_W-1:0];
          CFG_PATH_MIN_MTU:    min_mtu   = cfg_wdata[SIZE_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count <= errs;
    n_due      <= status_due_q.size();
  end

endmodule

[tb/sv/pmtu_probe_ack_tracker_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmtu_probe_ack_tracker_core_tb: testbench top for the probe tracker
// Drives directed probe and ack sequences, then random probe episodes with
// ack frames and noise under several register settings, with bursty input
// and a shifting stall pattern on the result side. Checking is done by the
// status checker beside the block.
// ----------------------------------------------------------------------------
module pmtu_probe_ack_tracker_core_tb;
  import pptrk_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam logic [PN_W-1:0] PN_MAX = {PN_W{1'b1}};

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  int       fail_count;
  int       n_due;
  int       n_sent = 0;
  int       burst_left = 0;
  int       quiet_cycles = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_tick = 0;

  pmtu_probe_ack_tracker_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pptrk_status_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .n_due      (n_due)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side stalls, pattern is redrawn when its random run length runs out
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 96);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= ((rx_tick % 9) >= 5);
    endcase
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [PN_W-1:0] rand62();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[PN_W-1:0];
  endfunction

  // small random value widened to a packet number
  function automatic logic [PN_W-1:0] rand_pn(input int unsigned lo, input int unsigned hi);
    return PN_W'($urandom_range(lo, hi));
  endfunction

  // fully random word, unused fields stay random in every builder below
  function automatic in_word_t noise_word();
    in_word_t w;
    w.action        = ACTION_W'($urandom_range(0, 7));
    w.packet_number = rand62();
    w.success       = 1'($urandom_range(0, 1));
    w.is_ack_frame  = 1'($urandom_range(0, 1));
    w.largest_acked = rand62();
    w.first_len     = rand62();
    w.gap           = rand62();
    w.range_length  = rand62();
    return w;
  endfunction

  function automatic in_word_t start_word(input logic [PN_W-1:0] pn);
    in_word_t w;
    w = noise_word();
    w.action        = ACT_START;
    w.packet_number = pn;
    return w;
  endfunction

  function automatic in_word_t result_word(input logic ok);
    in_word_t w;
    w = noise_word();
    w.action  = ACT_RESULT;
    w.success = ok;
    return w;
  endfunction

  function automatic in_word_t path_word();
    in_word_t w;
    w = noise_word();
    w.action = ACT_RESET;
    return w;
  endfunction

  function automatic in_word_t header_word(input logic is_ack, input logic [PN_W-1:0] largest,
                                           input logic [PN_W-1:0] first);
    in_word_t w;
    w = noise_word();
    w.action        = ACT_HDR;
    w.is_ack_frame  = is_ack;
    w.largest_acked = largest;
    w.first_len     = first;
    return w;
  endfunction

  function automatic in_word_t range_word(input logic [PN_W-1:0] gap_f,
                                          input logic [PN_W-1:0] len_f);
    in_word_t w;
    w = noise_word();
    w.action       = ACT_RANGE;
    w.gap          = gap_f;
    w.range_length = len_f;
    return w;
  endfunction

  // one input word, bursts with random gaps between them
  task automatic send_word(input in_word_t w);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    n_sent++;
  endtask

  // write all four registers, block must be idle
  task automatic load_regs(input logic [15:0] base, input logic [15:0] step,
                           input logic [15:0] cap, input logic [15:0] floor_mtu);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BASE_PROBE_SIZE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= CFG_PROBE_STEP;
    cfg_wdata <= step;
    @(posedge clk);
    cfg_index <= CFG_MAX_PROBE_SIZE;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_index <= CFG_PATH_MIN_MTU;
    cfg_wdata <= floor_mtu;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // stop sending and wait for every result to come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // start a probe, then an ack frame walking down toward it
  task automatic probe_episode();
    logic [PN_W-1:0] pn;
    logic [PN_W-1:0] largest;
    logic [PN_W-1:0] first;
    int              n_ranges;
    case ($urandom_range(0, 3))
      0:       pn = rand_pn(0, 1000);
      1:       pn = rand62();
      2:       pn = PN_MAX - rand_pn(0, 5000);
      default: pn = ($urandom_range(0, 3) == 0) ? '0 : rand_pn(1, 50);
    endcase
    send_word(start_word(pn));
    if ($urandom_range(0, 9) == 0) send_word(noise_word());
    // largest mostly at or above the probe, sometimes below it
    largest = ($urandom_range(0, 7) == 0) ? pn - rand_pn(1, 5) : pn + rand_pn(0, 60);
    first   = ($urandom_range(0, 9) == 0) ? rand62() : rand_pn(0, 40);
    send_word(header_word($urandom_range(0, 9) != 0, largest, first));
    n_ranges = $urandom_range(0, 8);
    repeat (n_ranges) begin
      if ($urandom_range(0, 11) == 0) send_word(range_word(rand62(), rand62()));
      else send_word(range_word(rand_pn(0, 10), rand_pn(0, 12)));
    end
    if ($urandom_range(0, 1) == 0) send_word(result_word(1'($urandom_range(0, 1))));
  endtask

  task automatic run_traffic(input int count);
    int stop_at;
    int pick;
    stop_at = n_sent + count;
    while (n_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) send_word(noise_word());
      else if (pick < 12) send_word(path_word());
      else probe_episode();
    end
  endtask

  // stimulus and verdict
  initial begin
    in_word_t w;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed sequence at reset register values
    send_word(result_word(1'b1));                   // result with nothing in flight
    send_word(range_word('0, '0));                  // extra range with no walk
    send_word(header_word(1'b1, PN_MAX, PN_MAX));   // header with nothing in flight
    send_word(start_word('0));                      // probe number zero
    send_word(header_word(1'b1, 62'd100, 62'd100)); // ineligible, zero probe number
    send_word(start_word(62'd100));
    send_word(header_word(1'b0, 62'd200, 62'd200)); // not an ack frame
    send_word(header_word(1'b1, 62'd50, '0));       // probe above largest
    send_word(header_word(1'b1, 62'd200, 62'd10));  // walk starts at 190
    send_word(range_word('0, 62'd5));               // 183..188, miss
    send_word(range_word(62'd80, 62'd10));          // 91..101, covers
    send_word(range_word('0, '0));                  // walk already over
    send_word(start_word(PN_MAX));                  // stepped target capped
    send_word(header_word(1'b1, PN_MAX, PN_MAX));   // first range down to zero
    send_word(start_word(62'd5));
    send_word(header_word(1'b1, 62'd10, 62'd20));   // first range wider than largest
    send_word(range_word(PN_MAX, PN_MAX));
    send_word(range_word('0, '0));
    send_word(result_word(1'b0));                   // probe lost
    send_word(path_word());                         // limit back to path minimum
    send_word(start_word(62'd3));                   // limit below base size
    send_word(header_word(1'b1, 62'd1000, '0));
    send_word(range_word('0, PN_MAX));              // low bound clamps at zero
    for (int k = 1; k <= 3; k++) begin
      w = noise_word();
      w.action = ACT_RANGE + 3'(k);                 // unused action codes
      send_word(w);
    end
    settle();

    // random traffic under several register settings
    load_regs(16'd1200, 16'd1, 16'd1200, 16'd1200);
    run_traffic(120);
    settle();
    load_regs(16'd65535, 16'd1024, 16'd65535, 16'd65535);
    run_traffic(120);
    settle();
    load_regs(16'd1200, 16'd1024, 16'd65535, 16'd1200);
    run_traffic(120);
    settle();
    load_regs(16'd65535, 16'd1, 16'd1200, 16'd65535);
    run_traffic(120);
    settle();
    repeat (2) begin
      load_regs(16'($urandom_range(1200, 65535)), 16'($urandom_range(1, 1024)),
                16'($urandom_range(1200, 65535)), 16'($urandom_range(1200, 65535)));
      run_traffic(120);
      settle();
    end

    if (fail_count == 0 && n_due == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
